// ----- rtl/lfu_pkg.sv -----
`timescale 1ns / 1ps
package lfu_pkg;

  localparam int ENTRIES  = 16;
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int KEY_W    = 32;
  localparam int VAL_W    = 32;
  localparam int USE_W    = 32;
  localparam int STAMP_W  = 48;
  localparam int CAP_W    = 5;
  localparam int REC_W    = KEY_W + VAL_W + USE_W + STAMP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic             load;     // capture the incoming transaction
    logic             clear;    // restart the search registers
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             cmp_en;   // RAM read data for cmp_idx is present
    logic [IDX_W-1:0] cmp_idx;
    logic             commit;   // write back and load the result
  } lfu_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
  } lfu_status_t;

endpackage

// ----- rtl/lfu_req_if.sv -----
`timescale 1ns / 1ps
interface lfu_req_if;
  import lfu_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    opcode;
  logic [KEY_W-1:0]        key;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output opcode, output key, output value, input ready);
  modport sink   (input valid, input opcode, input key, input value, output ready);
endinterface

// ----- rtl/lfu_rsp_if.sv -----
`timescale 1ns / 1ps
interface lfu_rsp_if;
  import lfu_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    found;
  logic signed [VAL_W-1:0] read_value;

  modport source (output valid, output found, output read_value, input ready);
  modport sink   (input valid, input found, input read_value, output ready);
endinterface

// ----- rtl/lfu_cache_lookup_replace.sv -----
`timescale 1ns / 1ps
// Channel  Role    Handshake      Payload
// in_ch    sink    valid/ready    opcode, key, value
// out_ch   source  valid/ready    found, read_value
// cfg      write   cfg_we         cfg_wdata -> capacity
//
// Each transaction takes an idle step to accept it, a scan reading the entry RAM one
// slot a cycle, a step to drain the registered read and a step to write back; the next
// is accepted only after write-back. The single-read-port entry RAM sets the pace.
// The result sits in an output register, so the next request is taken while it waits;
// write-back stalls only if that register is still full.
// Synchronous reset empties the table (valid flops), zeroes the access clock and
// sets capacity to 16; no clearing pass is needed.
module lfu_cache_lookup_replace (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [lfu_pkg::CAP_W-1:0] cfg_wdata,
  lfu_req_if.sink                   in_ch,
  lfu_rsp_if.source                 out_ch
);
  import lfu_pkg::*;

  lfu_cmd_t         cmd;
  lfu_status_t      status;
  logic             in_ready;
  logic [VAL_W-1:0] read_value;

  // sequencer: accept, scan, drain, write back
  lfu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // entry store, match/victim search, result register
  lfu_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_opcode      (in_ch.opcode),
    .in_key         (in_ch.key),
    .in_value       (in_ch.value),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_found      (out_ch.found),
    .out_read_value (read_value)
  );

  assign in_ch.ready       = in_ready;
  assign out_ch.read_value = read_value;

  // write-back never overruns a result still waiting
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_ch.valid || out_ch.ready))
    else $error("write-back while result register full");

  // after taking a transaction the block is busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second transaction taken during a scan");

  // a result appears only after a write-back step
  a_result_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(cmd.commit))
    else $error("result without write-back");

  // RAM read scan and write-back are never active together
  a_scan_xor_commit: assert property (@(posedge clk) disable iff (rst)
    !(cmd.rd_en && cmd.commit))
    else $error("scan overlaps write-back");

endmodule

// ----- rtl/lfu_ram.sv -----
`timescale 1ns / 1ps
module lfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/lfu_ctrl.sv -----
`timescale 1ns / 1ps
module lfu_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lfu_pkg::lfu_status_t status,
  output lfu_pkg::lfu_cmd_t    cmd
);
  import lfu_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  state_t           state;
  logic [IDX_W-1:0] cnt;
  logic [IDX_W-1:0] cmp_idx;
  logic             cmp_pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      cmp_idx  <= '0;
      cmp_pend <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          cmp_pend <= 1'b0;
          cnt      <= '0;
          if (in_valid) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          cmp_pend <= 1'b1;
          cmp_idx  <= cnt;
          cnt      <= cnt + IDX_W'(1);
          if (cnt == LAST_IDX) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          cmp_pend <= 1'b0;
          state    <= ST_COMMIT;
        end
        ST_COMMIT: begin
          if (status.out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.rd_addr = cnt;
    cmd.cmp_idx = cmp_idx;
    in_ready    = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.load  = in_valid;
        cmd.clear = in_valid;
      end
      ST_SCAN: begin
        cmd.rd_en  = 1'b1;
        cmd.cmp_en = cmp_pend;
      end
      ST_DRAIN: begin
        cmd.cmp_en = cmp_pend;
      end
      ST_COMMIT: begin
        cmd.commit = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/lfu_dp.sv -----
`timescale 1ns / 1ps
module lfu_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  lfu_pkg::lfu_cmd_t            cmd,
  output lfu_pkg::lfu_status_t         status,
  input  logic                         cfg_we,
  input  logic [lfu_pkg::CAP_W-1:0]    cfg_wdata,
  input  logic                         in_opcode,
  input  logic [lfu_pkg::KEY_W-1:0]    in_key,
  input  logic [lfu_pkg::VAL_W-1:0]    in_value,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic                         out_found,
  output logic [lfu_pkg::VAL_W-1:0]    out_read_value
);
  import lfu_pkg::*;

  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // transaction being served
  logic               op;
  logic [KEY_W-1:0]   key;
  logic [VAL_W-1:0]   val;

  // search results
  logic               hit_found;
  logic [IDX_W-1:0]   hit_idx;
  logic [VAL_W-1:0]   hit_val;
  logic [USE_W-1:0]   hit_cnt;
  logic               vic_found;
  logic [IDX_W-1:0]   vic_idx;
  logic [USE_W-1:0]   vic_cnt;
  logic [STAMP_W-1:0] vic_stamp;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;
  logic [CNT_W-1:0]   used;

  logic [ENTRIES-1:0] valid;
  logic [STAMP_W-1:0] clock;
  logic [CAP_W-1:0]   capacity;

  logic [REC_W-1:0]   rd_rec;
  logic [KEY_W-1:0]   rd_key;
  logic [VAL_W-1:0]   rd_val;
  logic [USE_W-1:0]   rd_cnt;
  logic [STAMP_W-1:0] rd_stamp;

  logic               do_write;
  logic               set_valid;
  logic [IDX_W-1:0]   slot;
  logic [VAL_W-1:0]   wr_val;
  logic [USE_W-1:0]   wr_cnt;
  logic [STAMP_W-1:0] stamp_next;
  logic [USE_W-1:0]   hit_cnt_next;
  logic [CMP_W-1:0]   cap_eff;
  logic               full;
  logic               vic_better;

  assign {rd_key, rd_val, rd_cnt, rd_stamp} = rd_rec;

  lfu_ram #(
    .WIDTH (REC_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.commit && do_write),
    .waddr (slot),
    .wdata ({key, wr_val, wr_cnt, stamp_next}),
    .re    (cmd.rd_en),
    .raddr (cmd.rd_addr),
    .rdata (rd_rec)
  );

  // lowest count wins, then oldest stamp; strict compare keeps the lower slot on a tie
  assign vic_better = !vic_found || (rd_cnt < vic_cnt) ||
                      ((rd_cnt == vic_cnt) && (rd_stamp < vic_stamp));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= in_opcode;
      key <= in_key;
      val <= in_value;
    end
    if (cmd.clear) begin
      hit_found  <= 1'b0;
      vic_found  <= 1'b0;
      free_found <= 1'b0;
      used       <= '0;
    end else if (cmd.cmp_en) begin
      if (valid[cmd.cmp_idx]) begin
        used <= used + CNT_W'(1);
        if (!hit_found && (rd_key == key)) begin
          hit_found <= 1'b1;
          hit_idx   <= cmd.cmp_idx;
          hit_val   <= rd_val;
          hit_cnt   <= rd_cnt;
        end
        if (vic_better) begin
          vic_found <= 1'b1;
          vic_idx   <= cmd.cmp_idx;
          vic_cnt   <= rd_cnt;
          vic_stamp <= rd_stamp;
        end
      end else if (!free_found) begin
        free_found <= 1'b1;
        free_idx   <= cmd.cmp_idx;
      end
    end
  end

  always_comb begin
    cap_eff = (CMP_W'(capacity) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : CMP_W'(capacity);
    full    = CMP_W'(used) >= cap_eff;
    stamp_next   = clock + STAMP_W'(1);
    hit_cnt_next = (hit_cnt == '1) ? hit_cnt : hit_cnt + USE_W'(1);
    do_write  = 1'b0;
    set_valid = 1'b0;
    slot      = hit_idx;
    wr_val    = hit_val;
    wr_cnt    = hit_cnt_next;
    if (op == OP_GET) begin
      do_write = hit_found;
    end else if (capacity != '0) begin
      wr_val = val;
      if (hit_found) begin
        do_write = 1'b1;
      end else begin
        do_write  = vic_found || free_found;
        set_valid = do_write;
        wr_cnt    = USE_W'(1);
        if (full && vic_found) begin
          slot = vic_idx;
        end else if (free_found) begin
          slot = free_idx;
        end else begin
          slot = vic_idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      clock     <= '0;
      capacity  <= CAP_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
        if (do_write) begin
          clock <= stamp_next;
        end
        if (set_valid) begin
          valid[slot] <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_found <= hit_found;
      if (op == OP_PUT) begin
        out_read_value <= '0;
      end else if (hit_found) begin
        out_read_value <= hit_val;
      end else begin
        out_read_value <= '1;
      end
    end
  end

  assign status.out_free = !out_valid || out_ready;

endmodule
